// ===== hw/rtl/bdpc_pkg.sv =====
// Shared types and constants for the button debounce and press classifier.
// No dependencies; imported by the top level and its port checker.
package bdpc_pkg;

    localparam int FIELD_W     = 9;    // raw level and event mask width
    localparam int ELAPSED_W   = 16;
    localparam int THR_W       = 24;
    localparam int HIST_LEN    = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 64;

    localparam int BUTTON_COUNT_DEF = 9;
    localparam int TIME_BITS_DEF    = 24;

    // history: bit 0 newest, 1 = released
    localparam logic [HIST_LEN-1:0] HIST_RELEASED = 13'h1FFF;
    localparam logic [HIST_LEN-1:0] HIST_PRESS    = 13'h1F00;
    localparam logic [HIST_LEN-1:0] HIST_HOLD     = 13'h0000;

    localparam logic [THR_W-1:0] SHORT_THR_RST  = 24'd250;
    localparam logic [THR_W-1:0] MEDIUM_THR_RST = 24'd1000;
    localparam logic [THR_W-1:0] LONG_THR_RST   = 24'd3000;

    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_THR   = 2'd2;

    typedef enum logic [2:0] {
        LVL_UP    = 3'd0,
        LVL_DOWN  = 3'd1,
        LVL_SHORT = 3'd2,
        LVL_MED   = 3'd3,
        LVL_LONG  = 3'd4
    } t_level;

endpackage

// ===== hw/rtl/button_debounce_press_classifier.sv =====
// Button debounce and press classifier, top level.
// Depends on bdpc_pkg; per-button history, press level and held-time registers.
//
// Each input word is one sampling tick: raw contact levels and the time since the
// previous tick. Every button keeps a 13-sample history; the pattern of five
// released then eight pressed samples gives a down event, thirteen released
// samples end the press, and thirteen pressed samples add the elapsed time into a
// saturating held-time counter that raises the level through short, medium and
// long. Each input word yields exactly one registered output word of event masks,
// and a new word is taken every cycle unless stalled: the per-button update is a
// single add and three compares between the state registers and the output
// register. The input side stalls only while the output register is full and not
// being drained. The threshold port is always ready; write it only while idle.
module button_debounce_press_classifier
    import bdpc_pkg::*;
#(
    parameter int BUTTON_COUNT = BUTTON_COUNT_DEF,
    parameter int TIME_BITS    = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // tick input
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // [8:0] raw_levels, [24:9] elapsed_ticks
    // event output
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // [8:0] down_events, [17:9] up_events,
                                                    // [26:18] tap_events, [35:27] short_events,
                                                    // [44:36] medium_events,
                                                    // [53:45] long_events, [62:54] held_mask
    // threshold writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [THR_W-1:0]      i_cfg_data
);

    localparam int CMP_W = (TIME_BITS > THR_W) ? TIME_BITS : THR_W;
    localparam int SUM_W = ((TIME_BITS > ELAPSED_W) ? TIME_BITS : ELAPSED_W) + 1;
    localparam logic [TIME_BITS-1:0] TIME_CAP = '1;

    logic [THR_W-1:0]     r_short_thr, r_medium_thr, r_long_thr;
    logic [HIST_LEN-1:0]  r_hist  [BUTTON_COUNT];
    t_level               r_level [BUTTON_COUNT];
    logic [TIME_BITS-1:0] r_held  [BUTTON_COUNT];
    logic                 r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [HIST_LEN-1:0]  n_hist  [BUTTON_COUNT];
    t_level               n_level [BUTTON_COUNT];
    logic [TIME_BITS-1:0] n_held  [BUTTON_COUNT];
    t_level               w_lv_mid [BUTTON_COUNT];
    logic [SUM_W-1:0]     w_sum   [BUTTON_COUNT];

    logic                 w_accept;
    logic [FIELD_W-1:0]   w_levels;
    logic [ELAPSED_W-1:0] w_elapsed;
    logic [BUTTON_COUNT-1:0] w_pressed;
    logic [BUTTON_COUNT-1:0] w_down, w_up, w_tap, w_short, w_med, w_long, w_held;
    logic [FIELD_W-1:0]   w_down_f, w_up_f, w_tap_f, w_short_f, w_med_f, w_long_f, w_held_f;

    assign w_levels  = i_s_axis_tdata[FIELD_W-1:0];
    assign w_elapsed = i_s_axis_tdata[FIELD_W +: ELAPSED_W];
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready = 1'b1;

    // buttons beyond the input field sample released
    for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_in
        if (g < FIELD_W) begin : g_live
            assign w_pressed[g] = w_levels[g];
        end else begin : g_idle
            assign w_pressed[g] = 1'b0;
        end
    end

    for (genvar g = 0; g < FIELD_W; g++) begin : g_out
        if (g < BUTTON_COUNT) begin : g_live
            assign w_down_f[g]  = w_down[g];
            assign w_up_f[g]    = w_up[g];
            assign w_tap_f[g]   = w_tap[g];
            assign w_short_f[g] = w_short[g];
            assign w_med_f[g]   = w_med[g];
            assign w_long_f[g]  = w_long[g];
            assign w_held_f[g]  = w_held[g];
        end else begin : g_none
            assign w_down_f[g]  = 1'b0;
            assign w_up_f[g]    = 1'b0;
            assign w_tap_f[g]   = 1'b0;
            assign w_short_f[g] = 1'b0;
            assign w_med_f[g]   = 1'b0;
            assign w_long_f[g]  = 1'b0;
            assign w_held_f[g]  = 1'b0;
        end
    end

    always_comb begin
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            n_hist[i]   = {r_hist[i][HIST_LEN-2:0], ~w_pressed[i]};
            w_lv_mid[i] = r_level[i];
            w_down[i]   = 1'b0;
            w_up[i]     = 1'b0;
            w_tap[i]    = 1'b0;
            w_short[i]  = 1'b0;
            w_med[i]    = 1'b0;
            w_long[i]   = 1'b0;

            if (n_hist[i] == HIST_PRESS) begin
                w_lv_mid[i] = LVL_DOWN;
                w_down[i]   = 1'b1;
            end else if (n_hist[i] == HIST_RELEASED) begin
                if (r_level[i] != LVL_UP) begin
                    w_up[i]  = 1'b1;
                    w_tap[i] = (r_level[i] == LVL_DOWN);
                end
                w_lv_mid[i] = LVL_UP;
            end

            w_sum[i]   = SUM_W'(r_held[i]) + SUM_W'(w_elapsed);
            n_level[i] = w_lv_mid[i];
            if (n_hist[i] == HIST_HOLD) begin
                n_held[i] = (w_sum[i] > SUM_W'(TIME_CAP)) ? TIME_CAP
                                                          : w_sum[i][TIME_BITS-1:0];
                if (CMP_W'(n_held[i]) > CMP_W'(r_long_thr)) begin
                    n_level[i] = LVL_LONG;
                    w_long[i]  = (w_lv_mid[i] != LVL_LONG);
                end else if (CMP_W'(n_held[i]) > CMP_W'(r_medium_thr)) begin
                    n_level[i] = LVL_MED;
                    w_med[i]   = (w_lv_mid[i] != LVL_MED);
                end else if (CMP_W'(n_held[i]) > CMP_W'(r_short_thr)) begin
                    n_level[i] = LVL_SHORT;
                    w_short[i] = (w_lv_mid[i] != LVL_SHORT);
                end
            end else begin
                n_held[i] = '0;
            end

            w_held[i] = (n_level[i] != LVL_UP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_thr  <= SHORT_THR_RST;
            r_medium_thr <= MEDIUM_THR_RST;
            r_long_thr   <= LONG_THR_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SHORT_THR:  r_short_thr  <= i_cfg_data;
                CFG_MEDIUM_THR: r_medium_thr <= i_cfg_data;
                CFG_LONG_THR:   r_long_thr   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                r_hist[i]  <= HIST_RELEASED;
                r_level[i] <= LVL_UP;
                r_held[i]  <= '0;
            end
        end else if (w_accept) begin
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                r_hist[i]  <= n_hist[i];
                r_level[i] <= n_level[i];
                r_held[i]  <= n_held[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {1'b0, w_held_f, w_long_f, w_med_f, w_short_f,
                           w_tap_f, w_up_f, w_down_f};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== hw/rtl/bdpc_checker.sv =====
// Port checker for the button debounce and press classifier, with its bind.
// Depends on bdpc_pkg; watches only the event output port of the top level.
module bdpc_checker
    import bdpc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] i_m_axis_tdata
);

    logic [FIELD_W-1:0] w_down, w_up, w_tap, w_short, w_med, w_long, w_held;

    assign w_down  = i_m_axis_tdata[0*FIELD_W +: FIELD_W];
    assign w_up    = i_m_axis_tdata[1*FIELD_W +: FIELD_W];
    assign w_tap   = i_m_axis_tdata[2*FIELD_W +: FIELD_W];
    assign w_short = i_m_axis_tdata[3*FIELD_W +: FIELD_W];
    assign w_med   = i_m_axis_tdata[4*FIELD_W +: FIELD_W];
    assign w_long  = i_m_axis_tdata[5*FIELD_W +: FIELD_W];
    assign w_held  = i_m_axis_tdata[6*FIELD_W +: FIELD_W];

    // a tap is always a release
    a_tap_is_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid |-> ((w_tap & ~w_up) == '0))
        else $error("tap event without up event");

    // released buttons are not held; pressed or promoted ones are
    a_up_not_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid |-> ((w_up & w_held) == '0 &&
                             ((w_down | w_short | w_med | w_long) & ~w_held) == '0))
        else $error("event inconsistent with held mask");

    // one level change per button per word
    a_levels_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid |-> ((w_down & (w_up | w_short | w_med | w_long)) == '0 &&
                             (w_short & (w_med | w_long)) == '0 &&
                             (w_med & w_long) == '0))
        else $error("conflicting level events");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_axis_tvalid && !i_m_axis_tready) |=>
            (i_m_axis_tvalid && $stable(i_m_axis_tdata)))
        else $error("stalled output word changed");

endmodule

bind button_debounce_press_classifier bdpc_checker u_bdpc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata)
);

// ===== sim/button_debounce_press_classifier_tb.sv =====
// Testbench for button_debounce_press_classifier: a per-button debounce and
// press-level predictor checks every output word. It drives random stalls on
// both stream sides. Depends on bdpc_pkg and the top level RTL only.
`timescale 1ns / 1ps

module button_debounce_press_classifier_tb;
    import bdpc_pkg::*;

    localparam int TIME_W      = TIME_BITS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [TIME_W-1:0] TIME_CAP = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [FIELD_W-1:0] held_mask;
        logic [FIELD_W-1:0] long_ev;
        logic [FIELD_W-1:0] medium_ev;
        logic [FIELD_W-1:0] short_ev;
        logic [FIELD_W-1:0] tap_ev;
        logic [FIELD_W-1:0] up_ev;
        logic [FIELD_W-1:0] down_ev;
    } t_event_masks;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  o_m_axis_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [THR_W-1:0]      cfg_data;

    // predictor state
    logic [HIST_LEN-1:0] hist_q  [FIELD_W];
    t_level              level_q [FIELD_W];
    logic [TIME_W-1:0]   held_q  [FIELD_W];
    logic [THR_W-1:0]    thr_short, thr_medium, thr_long;
    t_event_masks        expected_events[$];

    // random button behaviour: current level and ticks left in this run
    int run_left    [FIELD_W];
    bit run_pressed [FIELD_W];

    int sender_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int cycle_count;

    button_debounce_press_classifier dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic classify_tick(input logic [FIELD_W-1:0] raw,
                                 input logic [ELAPSED_W-1:0] elapsed);
        t_event_masks        m;
        logic [HIST_LEN-1:0] h;
        logic [TIME_W:0]     sum;
        m = '0;
        for (int i = 0; i < FIELD_W; i++) begin
            h = {hist_q[i][HIST_LEN-2:0], ~raw[i]};
            hist_q[i] = h;
            if (h == HIST_PRESS) begin
                level_q[i] = LVL_DOWN;
                m.down_ev[i] = 1'b1;
            end else if (h == HIST_RELEASED) begin
                if (level_q[i] != LVL_UP) begin
                    m.up_ev[i] = 1'b1;
                    if (level_q[i] < LVL_SHORT)
                        m.tap_ev[i] = 1'b1;
                end
                level_q[i] = LVL_UP;
            end
            if (h == HIST_HOLD) begin
                sum = {1'b0, held_q[i]} + (TIME_W + 1)'(elapsed);
                held_q[i] = (sum > TIME_CAP) ? TIME_CAP : sum[TIME_W-1:0];
                if (held_q[i] > thr_long) begin
                    if (level_q[i] != LVL_LONG) begin
                        level_q[i] = LVL_LONG;
                        m.long_ev[i] = 1'b1;
                    end
                end else if (held_q[i] > thr_medium) begin
                    if (level_q[i] != LVL_MED) begin
                        level_q[i] = LVL_MED;
                        m.medium_ev[i] = 1'b1;
                    end
                end else if (held_q[i] > thr_short) begin
                    if (level_q[i] != LVL_SHORT) begin
                        level_q[i] = LVL_SHORT;
                        m.short_ev[i] = 1'b1;
                    end
                end
            end else begin
                held_q[i] = '0;
            end
            m.held_mask[i] = (level_q[i] != LVL_UP);
        end
        expected_events.push_back(m);
    endtask

    task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] got,
                                   input logic [FIELD_W-1:0] want);
        if (mismatches < 40)
            $display("mismatch %s: got %03h want %03h at cycle %0d",
                     what, got, want, cycle_count);
        mismatches++;
    endtask

    task automatic compare_field(input string what, input logic [FIELD_W-1:0] got,
                                 input logic [FIELD_W-1:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin : check_events
        t_event_masks got, want;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            got = t_event_masks'(o_m_axis_tdata[$bits(t_event_masks)-1:0]);
            if (expected_events.size() == 0) begin
                report_mismatch("unexpected word", got.down_ev, '0);
            end else begin
                want = expected_events.pop_front();
                compare_field("down_events",   got.down_ev,   want.down_ev);
                compare_field("up_events",     got.up_ev,     want.up_ev);
                compare_field("tap_events",    got.tap_ev,    want.tap_ev);
                compare_field("short_events",  got.short_ev,  want.short_ev);
                compare_field("medium_events", got.medium_ev, want.medium_ev);
                compare_field("long_events",   got.long_ev,   want.long_ev);
                compare_field("held_mask",     got.held_mask, want.held_mask);
            end
        end
    end

    // valid is left high after acceptance; the next call lowers it or moves on
    task automatic send_tick(input logic [FIELD_W-1:0] raw,
                             input logic [ELAPSED_W-1:0] elapsed);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W - FIELD_W - ELAPSED_W){1'b0}}, elapsed, raw};
        do @(posedge i_clk); while (!o_s_axis_tready);
        classify_tick(raw, elapsed);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [THR_W-1:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SHORT_THR:  thr_short  = value;
            CFG_MEDIUM_THR: thr_medium = value;
            CFG_LONG_THR:   thr_long   = value;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_thresholds(input logic [THR_W-1:0] s_thr,
                                  input logic [THR_W-1:0] m_thr,
                                  input logic [THR_W-1:0] l_thr);
        wait_for_results();
        write_threshold(CFG_SHORT_THR, s_thr);
        write_threshold(CFG_MEDIUM_THR, m_thr);
        write_threshold(CFG_LONG_THR, l_thr);
    endtask

    // mostly clean press/release runs, some bounce and single-sample noise
    task automatic random_ticks(input int count);
        logic [FIELD_W-1:0]   raw;
        logic [ELAPSED_W-1:0] elapsed;
        int                   pick;
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < FIELD_W; i++) begin
                if (run_left[i] == 0) begin
                    run_pressed[i] = ~run_pressed[i];
                    pick = $urandom_range(9);
                    if (pick < 2)       run_left[i] = $urandom_range(1, 4);
                    else if (pick < 5)  run_left[i] = $urandom_range(5, 8);
                    else if (pick < 8)  run_left[i] = $urandom_range(9, 20);
                    else                run_left[i] = $urandom_range(21, 60);
                end
                run_left[i]--;
                raw[i] = run_pressed[i] ^ ($urandom_range(99) < 3);
            end
            case ($urandom_range(3))
                0: elapsed = ELAPSED_W'($urandom_range(15));
                1: elapsed = ELAPSED_W'($urandom_range(400));
                2: elapsed = ELAPSED_W'($urandom);
                default: elapsed = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            endcase
            send_tick(raw, elapsed);
        end
    endtask

    // clean press through short, medium and long, a tap, noise that never
    // forms the press pattern, and release of a button that was never down
    task automatic test_press_hold_release();
        logic [FIELD_W-1:0]   raw;
        logic [ELAPSED_W-1:0] elapsed;
        for (int t = 1; t <= 15; t++) begin
            raw = 9'h0DB;
            raw[2] = (t <= 8);
            raw[5] = (t != 3);
            if (t <= 12)      elapsed = t[0] ? 16'hFFFF : 16'h0000;
            else if (t == 13) elapsed = 16'd251;
            else if (t == 14) elapsed = 16'd750;
            else              elapsed = 16'd2000;
            send_tick(raw, elapsed);
        end
        for (int t = 0; t < 13; t++)
            send_tick('0, 16'hFFFF);
    endtask

    task automatic test_threshold_extremes();
        set_thresholds('0, '0, '0);
        random_ticks(100);
        set_thresholds('1, '1, '1);
        random_ticks(100);
    endtask

    task automatic test_random_thresholds();
        logic [THR_W-1:0] s_thr, m_thr, l_thr;
        set_thresholds(SHORT_THR_RST, MEDIUM_THR_RST, LONG_THR_RST);
        random_ticks(200);
        for (int r = 0; r < 3; r++) begin
            if (r == 0) begin
                s_thr = THR_W'($urandom_range(600));
                m_thr = s_thr + THR_W'($urandom_range(1500));
                l_thr = m_thr + THR_W'($urandom_range(3000));
            end else if (r == 1) begin
                s_thr = THR_W'($urandom_range(4000));
                m_thr = THR_W'($urandom_range(4000));
                l_thr = THR_W'($urandom_range(4000));
            end else begin
                s_thr = THR_W'($urandom);
                m_thr = THR_W'($urandom);
                l_thr = THR_W'($urandom);
            end
            set_thresholds(s_thr, m_thr, l_thr);
            random_ticks(100);
        end
    endtask

    // the long level is only passed once the held time saturates
    task automatic test_held_time_saturation();
        set_thresholds('0, 24'h7FFFFF, 24'hFFFFFE);
        for (int t = 0; t < 270; t++)
            send_tick('1, 16'hFFFF);
        for (int t = 0; t < 13; t++)
            send_tick('0, ELAPSED_W'($urandom));
    endtask

    task automatic test_unused_index();
        wait_for_results();
        write_threshold(CFG_UNUSED, THR_W'($urandom));
        set_thresholds(24'd40, 24'd300, 24'd900);
        random_ticks(150);
    endtask

    initial begin
        i_rst_n   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        mismatches  = 0;
        cycle_count = 0;
        thr_short  = SHORT_THR_RST;
        thr_medium = MEDIUM_THR_RST;
        thr_long   = LONG_THR_RST;
        for (int i = 0; i < FIELD_W; i++) begin
            hist_q[i]      = HIST_RELEASED;
            level_q[i]     = LVL_UP;
            held_q[i]      = '0;
            run_left[i]    = 0;
            run_pressed[i] = 1'b1;
        end
        sender_idle_pct = 8;
        recv_idle_pct   = 69;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_press_hold_release();
        test_threshold_extremes();
        sender_idle_pct = 69;
        recv_idle_pct   = 8;
        test_random_thresholds();
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        test_held_time_saturation();
        test_unused_index();

        wait_for_results();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_events.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
